/* src/fbpa_pkg.sv */
// Shared types, codes and widths for the fixed block pool allocator.
`default_nettype none

package fbpa_pkg;

    localparam int MAX_BINS_DEF   = 1024;
    localparam int POOL_BYTES_DEF = 65536;

    localparam int SIZE_W    = 17;
    localparam int COUNT_W   = 11;
    localparam int OFFSET_W  = 16;
    localparam int STATUS_W  = 3;
    localparam int CNT32_W   = 32;
    localparam int CFG_IDX_W = 1;
    localparam int CMP_W     = 32;

    localparam logic [SIZE_W-1:0]  BIN_BYTES_RST = SIZE_W'(64);
    localparam logic [COUNT_W-1:0] BIN_COUNT_RST = COUNT_W'(1024);

    typedef enum logic [0:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 3'd0,
        ST_POOL_FULL = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_FREED     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIN_BYTES = 1'b0,
        REG_BIN_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_READ,
        S_EXEC,
        S_OUT
    } fsm_state_t;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic exec;
        logic load_out;
    } dp_cmd_t;

    function automatic int div_width(int pool_bytes);
        int w;
        w = $clog2(pool_bytes + 1);
        return (w > OFFSET_W) ? w : OFFSET_W;
    endfunction

endpackage

`default_nettype wire

/* src/fbpa_div.sv */
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module fbpa_div #(
    parameter int DVD_W = 17,
    parameter int DVS_W = 17
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic      [DVD_W-1:0] quotient,
    output logic      [DVS_W-1:0] remainder,
    output logic                  done
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0] shifted;
    logic [DVS_W:0] diff;
    logic           ge;

    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

/* src/fbpa_datapath.sv */
// Allocator datapath: configuration, bookkeeping state, memories and result register.
`default_nettype none

module fbpa_datapath #(
    parameter int MAX_BINS   = fbpa_pkg::MAX_BINS_DEF,
    parameter int POOL_BYTES = fbpa_pkg::POOL_BYTES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fbpa_pkg::SIZE_W-1:0]      cfg_wdata,
    input  wire logic                             s_command,
    input  wire logic [fbpa_pkg::SIZE_W-1:0]      s_request_size,
    input  wire logic [fbpa_pkg::OFFSET_W-1:0]    s_free_offset,
    input  wire fbpa_pkg::dp_cmd_t                cmd,
    output logic                                  div_done,
    output logic      [fbpa_pkg::OFFSET_W-1:0]    m_bin_offset,
    output logic      [fbpa_pkg::STATUS_W-1:0]    m_status,
    output logic      [fbpa_pkg::COUNT_W-1:0]     m_bins_in_use,
    output logic      [fbpa_pkg::CNT32_W-1:0]     m_alloc_requests,
    output logic      [fbpa_pkg::CNT32_W-1:0]     m_free_requests,
    output logic      [fbpa_pkg::CNT32_W-1:0]     m_requested_bytes
);

    import fbpa_pkg::*;

    localparam int IDX_W  = $clog2(MAX_BINS);
    localparam int TOP_W  = $clog2(MAX_BINS + 1);
    localparam int DIV_W  = div_width(POOL_BYTES);
    localparam int PROD_W = IDX_W + SIZE_W;
    localparam logic [CMP_W-1:0] MAX_BINS_C = CMP_W'(MAX_BINS);
    localparam logic [DIV_W-1:0] POOL_C     = DIV_W'(POOL_BYTES);

    logic [SIZE_W-1:0]   bin_bytes_reg;
    logic [COUNT_W-1:0]  bin_count_reg;
    logic                cmd_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [OFFSET_W-1:0] offs_reg;

    logic [TOP_W-1:0]   free_top_reg,   free_top_next;
    logic [TOP_W-1:0]   fresh_bins_reg, fresh_bins_next;
    logic [COUNT_W-1:0] in_use_reg,     in_use_next;
    logic [CNT32_W-1:0] alloc_cnt_reg,  alloc_cnt_next;
    logic [CNT32_W-1:0] free_cnt_reg,   free_cnt_next;
    logic [CNT32_W-1:0] byte_cnt_reg,   byte_cnt_next;
    status_t            status_reg,     status_next;
    logic [OFFSET_W-1:0] prod_reg;

    logic [IDX_W-1:0] stack_mem [MAX_BINS];
    logic             map_mem   [MAX_BINS];
    logic [IDX_W-1:0] stack_rd_reg;
    logic             map_rd_reg;

    logic [OFFSET_W-1:0] out_offset_reg;
    status_t             out_status_reg;
    logic [COUNT_W-1:0]  out_in_use_reg;
    logic [CNT32_W-1:0]  out_alloc_reg;
    logic [CNT32_W-1:0]  out_free_reg;
    logic [CNT32_W-1:0]  out_bytes_reg;

    logic [SIZE_W-1:0] bs;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_W-1:0]  quot;
    logic [SIZE_W-1:0] rem;

    logic [IDX_W-1:0]  stack_raddr;
    logic [IDX_W-1:0]  quot_idx;
    logic [IDX_W-1:0]  alloc_idx;
    logic [PROD_W-1:0] prod_full;

    logic             stack_we;
    logic             map_we;
    logic [IDX_W-1:0] map_waddr;
    logic             map_wdata;

    logic [CMP_W-1:0] in_use_c;
    logic [CMP_W-1:0] quot_c;
    logic [CMP_W-1:0] fresh_c;
    logic             full_cap;
    logic             too_large;
    logic             have_free;
    logic             have_fresh;
    logic             free_ok;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_bytes_reg <= BIN_BYTES_RST;
            bin_count_reg <= BIN_COUNT_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BIN_BYTES: bin_bytes_reg <= cfg_wdata;
                REG_BIN_COUNT: bin_count_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // capture the input transaction
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg  <= s_command;
            size_reg <= s_request_size;
            offs_reg <= s_free_offset;
        end
    end

    assign bs       = (bin_bytes_reg == '0) ? SIZE_W'(1) : bin_bytes_reg;
    assign dividend = (cmd_reg == CMD_FREE) ? DIV_W'(offs_reg) : POOL_C;

    fbpa_div #(
        .DVD_W (DIV_W),
        .DVS_W (SIZE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (dividend),
        .divisor   (bs),
        .quotient  (quot),
        .remainder (rem),
        .done      (div_done)
    );

    assign stack_raddr = IDX_W'(free_top_reg - TOP_W'(1));
    assign quot_idx    = quot[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        stack_rd_reg <= stack_mem[stack_raddr];
        map_rd_reg   <= map_mem[quot_idx];
        if (stack_we) begin
            stack_mem[free_top_reg[IDX_W-1:0]] <= quot_idx;
        end
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
    end

    assign in_use_c   = CMP_W'(in_use_reg);
    assign quot_c     = CMP_W'(quot);
    assign fresh_c    = CMP_W'(fresh_bins_reg);
    assign full_cap   = (in_use_c >= CMP_W'(bin_count_reg)) || (in_use_c >= MAX_BINS_C)
                        || (in_use_c >= quot_c);
    assign too_large  = size_reg > bin_bytes_reg;
    assign have_free  = free_top_reg != '0;
    assign have_fresh = fresh_c < MAX_BINS_C;
    assign free_ok    = (rem == '0) && (quot_c < fresh_c) && (quot_c < MAX_BINS_C)
                        && map_rd_reg && (CMP_W'(free_top_reg) < MAX_BINS_C);

    assign alloc_idx = have_free ? stack_rd_reg : fresh_bins_reg[IDX_W-1:0];
    assign prod_full = PROD_W'(alloc_idx) * PROD_W'(bs);

    always_comb begin
        free_top_next   = free_top_reg;
        fresh_bins_next = fresh_bins_reg;
        in_use_next     = in_use_reg;
        alloc_cnt_next  = alloc_cnt_reg;
        free_cnt_next   = free_cnt_reg;
        byte_cnt_next   = byte_cnt_reg;
        status_next     = status_reg;
        stack_we        = 1'b0;
        map_we          = 1'b0;
        map_waddr       = alloc_idx;
        map_wdata       = 1'b1;
        if (cmd.exec) begin
            if (cmd_reg == CMD_ALLOC) begin
                alloc_cnt_next = alloc_cnt_reg + CNT32_W'(1);
                byte_cnt_next  = byte_cnt_reg + CNT32_W'(size_reg);
                if (full_cap) begin
                    status_next = ST_POOL_FULL;
                end else if (too_large) begin
                    status_next = ST_TOO_LARGE;
                end else if (have_free) begin
                    free_top_next = free_top_reg - TOP_W'(1);
                    map_we        = 1'b1;
                    in_use_next   = in_use_reg + COUNT_W'(1);
                    status_next   = ST_ALLOCATED;
                end else if (have_fresh) begin
                    fresh_bins_next = fresh_bins_reg + TOP_W'(1);
                    map_we          = 1'b1;
                    in_use_next     = in_use_reg + COUNT_W'(1);
                    status_next     = ST_ALLOCATED;
                end else begin
                    status_next = ST_POOL_FULL;
                end
            end else begin
                free_cnt_next = free_cnt_reg + CNT32_W'(1);
                if (free_ok) begin
                    map_we        = 1'b1;
                    map_waddr     = quot_idx;
                    map_wdata     = 1'b0;
                    stack_we      = 1'b1;
                    free_top_next = free_top_reg + TOP_W'(1);
                    if (in_use_reg != '0) begin
                        in_use_next = in_use_reg - COUNT_W'(1);
                    end
                    status_next = ST_FREED;
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_top_reg   <= '0;
            fresh_bins_reg <= '0;
            in_use_reg     <= '0;
            alloc_cnt_reg  <= '0;
            free_cnt_reg   <= '0;
            byte_cnt_reg   <= '0;
            status_reg     <= ST_ALLOCATED;
        end else begin
            free_top_reg   <= free_top_next;
            fresh_bins_reg <= fresh_bins_next;
            in_use_reg     <= in_use_next;
            alloc_cnt_reg  <= alloc_cnt_next;
            free_cnt_reg   <= free_cnt_next;
            byte_cnt_reg   <= byte_cnt_next;
            status_reg     <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            prod_reg <= prod_full[OFFSET_W-1:0];
        end
    end

    // hold the result until the transaction is taken
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_offset_reg <= (status_reg == ST_ALLOCATED) ? prod_reg : '0;
            out_status_reg <= status_reg;
            out_in_use_reg <= in_use_reg;
            out_alloc_reg  <= alloc_cnt_reg;
            out_free_reg   <= free_cnt_reg;
            out_bytes_reg  <= byte_cnt_reg;
        end
    end

    assign m_bin_offset      = out_offset_reg;
    assign m_status          = out_status_reg;
    assign m_bins_in_use     = out_in_use_reg;
    assign m_alloc_requests  = out_alloc_reg;
    assign m_free_requests   = out_free_reg;
    assign m_requested_bytes = out_bytes_reg;

endmodule

`default_nettype wire

/* src/fbpa_ctrl.sv */
// Allocator controller: sequences one transaction through the datapath.
`default_nettype none

module fbpa_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire logic              div_done,
    output fbpa_pkg::dp_cmd_t      cmd
);

    import fbpa_pkg::*;

    fsm_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_valid) begin
                state_next = S_START;
            end
            S_START: state_next = S_DIV;
            S_DIV:   if (div_done) begin
                state_next = S_READ;
            end
            S_READ:  state_next = S_EXEC;
            S_EXEC:  state_next = S_OUT;
            S_OUT:   if (out_free) begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = (m_valid_reg && !m_ready);
        unique case (state_reg)
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            S_START: cmd.div_start = 1'b1;
            S_EXEC:  cmd.exec = 1'b1;
            S_OUT: begin
                cmd.load_out = out_free;
                if (out_free) begin
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

/* src/fixed_block_pool_allocator.sv */
// Top level of the fixed block pool allocator.
//
// Hands out equal-size bins of a pool and takes them back. Each transaction is
// an allocate (pop the most recently freed bin, else the next fresh bin) or a
// free by byte offset, and yields exactly one result with status and running
// counters. One transaction is in flight at a time. The serial divider, DIV_W
// bits wide where DIV_W is the larger of 16 and the bit width of POOL_BYTES,
// computes the pool capacity for an allocate and the bin index and alignment
// for a free, one quotient bit per cycle. A new transaction is taken while the
// previous result still waits on m_ready.
// Configuration: index 0 is the bin size in bytes, index 1 is the bin count;
// write only while idle.
`default_nettype none

module fixed_block_pool_allocator #(
    parameter int MAX_BINS   = fbpa_pkg::MAX_BINS_DEF,
    parameter int POOL_BYTES = fbpa_pkg::POOL_BYTES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fbpa_pkg::SIZE_W-1:0]      cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_command,
    input  wire logic [fbpa_pkg::SIZE_W-1:0]      s_request_size,
    input  wire logic [fbpa_pkg::OFFSET_W-1:0]    s_free_offset,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [fbpa_pkg::OFFSET_W-1:0]    m_bin_offset,
    output logic      [fbpa_pkg::STATUS_W-1:0]    m_status,
    output logic      [fbpa_pkg::COUNT_W-1:0]     m_bins_in_use,
    output logic      [fbpa_pkg::CNT32_W-1:0]     m_alloc_requests,
    output logic      [fbpa_pkg::CNT32_W-1:0]     m_free_requests,
    output logic      [fbpa_pkg::CNT32_W-1:0]     m_requested_bytes
);

    import fbpa_pkg::*;

    dp_cmd_t cmd;
    logic    div_done;

    fbpa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .div_done (div_done),
        .cmd      (cmd)
    );

    fbpa_datapath #(
        .MAX_BINS   (MAX_BINS),
        .POOL_BYTES (POOL_BYTES)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_command         (s_command),
        .s_request_size    (s_request_size),
        .s_free_offset     (s_free_offset),
        .cmd               (cmd),
        .div_done          (div_done),
        .m_bin_offset      (m_bin_offset),
        .m_status          (m_status),
        .m_bins_in_use     (m_bins_in_use),
        .m_alloc_requests  (m_alloc_requests),
        .m_free_requests   (m_free_requests),
        .m_requested_bytes (m_requested_bytes)
    );

endmodule

`default_nettype wire

/* src/fbpa_checker.sv */
// Port-level checks for the fixed block pool allocator, bound to the top level.
`default_nettype none

module fbpa_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_valid,
    input wire logic                             s_ready,
    input wire logic                             m_valid,
    input wire logic                             m_ready,
    input wire logic [fbpa_pkg::OFFSET_W-1:0]    m_bin_offset,
    input wire logic [fbpa_pkg::STATUS_W-1:0]    m_status,
    input wire logic [fbpa_pkg::COUNT_W-1:0]     m_bins_in_use,
    input wire logic [fbpa_pkg::CNT32_W-1:0]     m_alloc_requests,
    input wire logic [fbpa_pkg::CNT32_W-1:0]     m_free_requests,
    input wire logic [fbpa_pkg::CNT32_W-1:0]     m_requested_bytes
);

    import fbpa_pkg::*;

    // hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_bin_offset)
            && $stable(m_bins_in_use) && $stable(m_alloc_requests)
            && $stable(m_free_requests) && $stable(m_requested_bytes))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while one is in flight");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_ALLOCATED) |-> m_bin_offset == '0)
        else $error("nonzero offset on a result that allocated nothing");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_ALLOCATED) |-> m_bins_in_use != '0)
        else $error("allocation reported with no bins in use");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);

`default_nettype wire
